### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the trigger holds, the consequence holds in the same cycle.
`define ASSERT_IMPLY(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mds_pkg.sv
// ----------------------------------------------------------------------------
// mds_pkg
// Types and constants shared by the multiplexed display scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mds_pkg;

   localparam int NUM_DIGITS = 7;

   localparam int DIGIT_W   = 3;
   localparam int PATTERN_W = 16;
   localparam int SOURCE_W  = 8;
   localparam int PERIOD_W  = 16;
   localparam int BRIGHT_W  = 7;
   localparam int PRODUCT_W = PERIOD_W + BRIGHT_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [BRIGHT_W-1:0]  BRIGHT_FULL  = BRIGHT_W'(100);
   localparam logic [PRODUCT_W-1:0] PCT_STEP     = PRODUCT_W'(100);
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(4999);
   localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET = BRIGHT_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT = CSR_IDX_W'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic                 en;
      logic [DIGIT_W-1:0]   digit;
      logic [PATTERN_W-1:0] pattern;
   } pat_wr_type;

endpackage

`default_nettype wire

### rtl/core/mds_pattern_store.sv
// ----------------------------------------------------------------------------
// mds_pattern_store
// Holds one segment pattern per digit, cleared at reset. Writes to a digit
// index beyond the digit count are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_pattern_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mds_pkg::pat_wr_type             wr,
   input  wire logic [mds_pkg::DIGIT_W-1:0]     rd_digit,
   output logic      [mds_pkg::PATTERN_W-1:0]   rd_pattern
);

   logic [mds_pkg::PATTERN_W-1:0] pattern_ff [mds_pkg::NUM_DIGITS];
   logic                          in_range;

   assign in_range = ({1'b0, wr.digit} < (mds_pkg::DIGIT_W+1)'(mds_pkg::NUM_DIGITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mds_pkg::NUM_DIGITS; i++) begin
            pattern_ff[i] <= '0;
         end
      end else if (wr.en && in_range) begin
         pattern_ff[wr.digit] <= wr.pattern;
      end
   end

   assign rd_pattern = pattern_ff[rd_digit];

endmodule

`default_nettype wire

### rtl/core/multiplexed_display_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_display_scanner
// Pipeline: an accepted transaction waits in the input register, and its result is registered in the output stage.
// Throughput: one transaction per cycle; a held result stalls the input only
// once the input register also holds a transaction.
// Reset: synchronous; clears the pattern store, the scan state and the
// configuration registers to their defaults (period 4999, brightness 100).
// Scans a multiplexed segment display with on-time dimming per digit slot.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multiplexed_display_scanner (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_op,
   input  wire logic [mds_pkg::DIGIT_W-1:0]        req_write_digit,
   input  wire logic [mds_pkg::PATTERN_W-1:0]      req_write_pattern,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [mds_pkg::PATTERN_W-1:0]      rsp_sink_pattern,
   output logic      [mds_pkg::SOURCE_W-1:0]       rsp_source_lines,
   output logic                                    rsp_blank,
   output logic      [mds_pkg::DIGIT_W-1:0]        rsp_active_digit,

   input  wire logic                               csr_write_enable,
   input  wire logic [mds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mds_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   logic [mds_pkg::PERIOD_W-1:0]  period_ff, period_in;
   logic [mds_pkg::BRIGHT_W-1:0]  bright_ff, bright_in;
   logic [mds_pkg::PRODUCT_W-1:0] thresh_ff, thresh_in;

   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic [mds_pkg::DIGIT_W-1:0]   in_digit_ff;
   logic [mds_pkg::PATTERN_W-1:0] in_pattern_ff;

   logic                          out_valid_ff;
   logic [mds_pkg::PERIOD_W-1:0]  scan_count_ff, scan_count_in;
   logic [mds_pkg::PRODUCT_W-1:0] scan_hund_ff, scan_hund_in;
   logic [mds_pkg::DIGIT_W-1:0]   digit_ff, digit_in;
   logic [mds_pkg::SOURCE_W-1:0]  source_ff, source_in;
   logic [mds_pkg::PATTERN_W-1:0] sink_ff, sink_in;
   logic                          blank_ff, blank_in;

   logic                          advance;
   logic                          process;
   logic                          is_tick;
   logic                          wrap;
   logic                          last_digit;
   logic [mds_pkg::DIGIT_W-1:0]   next_digit;
   logic [mds_pkg::PATTERN_W-1:0] next_pattern;
   logic [mds_pkg::PRODUCT_W-1:0] thresh_diff;
   logic                          hit;
   mds_pkg::pat_wr_type           store_wr;

   // Configuration registers; the on-time threshold product follows them.
   always_comb begin
      period_in = period_ff;
      bright_in = bright_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mds_pkg::CSR_PERIOD: period_in = csr_write_data;
            mds_pkg::CSR_BRIGHT: bright_in = csr_write_data[mds_pkg::BRIGHT_W-1:0];
            default: ;
         endcase
      end
      thresh_in = mds_pkg::PRODUCT_W'(period_in) * mds_pkg::PRODUCT_W'(bright_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= mds_pkg::PERIOD_RESET;
         bright_ff <= mds_pkg::BRIGHT_RESET;
         thresh_ff <= mds_pkg::PRODUCT_W'(mds_pkg::PERIOD_RESET) *
                      mds_pkg::PRODUCT_W'(mds_pkg::BRIGHT_RESET);
      end else begin
         period_ff <= period_in;
         bright_ff <= bright_in;
         thresh_ff <= thresh_in;
      end
   end

   // Pipeline control.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign process   = in_valid_ff && advance;
   assign is_tick   = (in_op_ff == mds_pkg::OP_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff      <= req_op;
         in_digit_ff   <= req_write_digit;
         in_pattern_ff <= req_write_pattern;
      end
   end

   assign store_wr.en      = process && (in_op_ff == mds_pkg::OP_WRITE);
   assign store_wr.digit   = in_digit_ff;
   assign store_wr.pattern = in_pattern_ff;

   mds_pattern_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (store_wr),
      .rd_digit   (next_digit),
      .rd_pattern (next_pattern)
   );

   // Scan step. The counter is also kept scaled by 100 so that the blanking
   // point compares against the threshold product without a divider.
   assign wrap        = (scan_count_ff >= period_ff);
   assign last_digit  = (digit_ff == mds_pkg::DIGIT_W'(mds_pkg::NUM_DIGITS - 1));
   assign next_digit  = last_digit ? '0 : digit_ff + mds_pkg::DIGIT_W'(1);

   always_comb begin
      scan_count_in = scan_count_ff;
      scan_hund_in  = scan_hund_ff;
      digit_in      = digit_ff;
      source_in     = source_ff;
      sink_in       = sink_ff;
      blank_in      = blank_ff;
      if (is_tick) begin
         if (wrap) begin
            scan_count_in = '0;
            scan_hund_in  = '0;
            digit_in      = next_digit;
            source_in     = {source_ff[mds_pkg::SOURCE_W-2:0], last_digit};
            sink_in       = next_pattern;
            blank_in      = 1'b0;
         end else begin
            scan_count_in = scan_count_ff + mds_pkg::PERIOD_W'(1);
            scan_hund_in  = scan_hund_ff + mds_pkg::PCT_STEP;
         end
         if (hit) begin
            blank_in = 1'b1;
         end
      end
   end

   assign thresh_diff = thresh_ff - scan_hund_in;
   assign hit = (bright_ff < mds_pkg::BRIGHT_FULL) && (thresh_ff >= scan_hund_in) &&
                (thresh_diff < mds_pkg::PCT_STEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         scan_count_ff <= '0;
         scan_hund_ff  <= '0;
         digit_ff      <= '0;
         source_ff     <= '0;
         sink_ff       <= '0;
         blank_ff      <= 1'b1;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            scan_count_ff <= scan_count_in;
            scan_hund_ff  <= scan_hund_in;
            digit_ff      <= digit_in;
            source_ff     <= source_in;
            sink_ff       <= sink_in;
            blank_ff      <= blank_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sink_pattern = sink_ff;
   assign rsp_source_lines = source_ff;
   assign rsp_blank        = blank_ff;
   assign rsp_active_digit = digit_ff;

   `ASSERT_ALWAYS(a_hund_tracks_count,
      scan_hund_ff == mds_pkg::PRODUCT_W'(scan_count_ff) * mds_pkg::PCT_STEP,
      "Scaled scan counter is out of step with the scan counter.")
   `ASSERT_ALWAYS(a_digit_in_range,
      {1'b0, digit_ff} < (mds_pkg::DIGIT_W+1)'(mds_pkg::NUM_DIGITS),
      "Active digit is beyond the digit count.")
   `ASSERT_NEXT(a_tick_count_step, process && is_tick,
      scan_count_ff == '0 || scan_count_ff == $past(scan_count_ff) + mds_pkg::PERIOD_W'(1),
      "Scan counter neither wrapped nor advanced by one on a tick.")
   `ASSERT_NEXT(a_full_bright_no_blank, process && (bright_ff >= mds_pkg::BRIGHT_FULL),
      !$rose(blank_ff),
      "Output blanked while brightness is at full scale.")
   `ASSERT_NEXT(a_write_keeps_scan, process && !is_tick,
      $stable(scan_count_ff) && $stable(digit_ff) && $stable(source_ff) && $stable(blank_ff),
      "A pattern write transaction changed the scan state.")

endmodule

`default_nettype wire

### dv/scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display scanner checker
// Watches the request, result and register ports of the scanner. It keeps
// its own copy of the pattern store, the scan state and the settings, and
// works out the view each accepted transaction should produce. Each accepted
// result is compared field by field against the oldest outstanding view.
// ----------------------------------------------------------------------------
module scan_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic                           req_op,
   input  wire logic [mds_pkg::DIGIT_W-1:0]    req_write_digit,
   input  wire logic [mds_pkg::PATTERN_W-1:0]  req_write_pattern,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [mds_pkg::PATTERN_W-1:0]  rsp_sink_pattern,
   input  wire logic [mds_pkg::SOURCE_W-1:0]   rsp_source_lines,
   input  wire logic                           rsp_blank,
   input  wire logic [mds_pkg::DIGIT_W-1:0]    rsp_active_digit,
   input  wire logic                           csr_write_enable,
   input  wire logic [mds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mds_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                                  mismatches,
   output int                                  pending
);

   typedef struct packed {
      logic [mds_pkg::PATTERN_W-1:0] sink;
      logic [mds_pkg::SOURCE_W-1:0]  source;
      logic                          blank;
      logic [mds_pkg::DIGIT_W-1:0]   digit;
   } scan_view_type;

   logic [mds_pkg::PATTERN_W-1:0] pattern_store [mds_pkg::NUM_DIGITS];
   logic [mds_pkg::PERIOD_W-1:0]  period_ticks;
   logic [mds_pkg::BRIGHT_W-1:0]  brightness;
   logic [mds_pkg::PERIOD_W-1:0]  scan_count;
   logic [mds_pkg::DIGIT_W-1:0]   digit_now;
   logic [mds_pkg::SOURCE_W-1:0]  source_now;
   logic [mds_pkg::PATTERN_W-1:0] sink_now;
   logic                          blank_now;
   scan_view_type                 expected_views [$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic note_mismatch(input string what,
                                input logic [mds_pkg::PATTERN_W-1:0] want,
                                input logic [mds_pkg::PATTERN_W-1:0] got);
      if (mismatches < 10)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   task automatic scan_item(input logic op, input logic [mds_pkg::DIGIT_W-1:0] dig,
                            input logic [mds_pkg::PATTERN_W-1:0] pat);
      logic [mds_pkg::PRODUCT_W-1:0] blank_point;
      if (op == mds_pkg::OP_WRITE) begin
         if (dig < mds_pkg::NUM_DIGITS)
            pattern_store[dig] = pat;
      end else begin
         if (scan_count >= period_ticks) begin
            scan_count = '0;
            if (digit_now == mds_pkg::DIGIT_W'(mds_pkg::NUM_DIGITS - 1)) begin
               digit_now  = '0;
               source_now = {source_now[mds_pkg::SOURCE_W-2:0], 1'b1};
            end else begin
               digit_now  = digit_now + 1'b1;
               source_now = {source_now[mds_pkg::SOURCE_W-2:0], 1'b0};
            end
            sink_now  = pattern_store[digit_now];
            blank_now = 1'b0;
         end else begin
            scan_count = scan_count + 1'b1;
         end
         blank_point = (mds_pkg::PRODUCT_W'(period_ticks) *
                        mds_pkg::PRODUCT_W'(brightness)) / mds_pkg::PCT_STEP;
         if (brightness < mds_pkg::BRIGHT_FULL &&
             mds_pkg::PRODUCT_W'(scan_count) == blank_point)
            blank_now = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      scan_view_type want;
      if (reset) begin
         foreach (pattern_store[i])
            pattern_store[i] = '0;
         period_ticks = mds_pkg::PERIOD_RESET;
         brightness   = mds_pkg::BRIGHT_RESET;
         scan_count   = '0;
         digit_now    = '0;
         source_now   = '0;
         sink_now     = '0;
         blank_now    = 1'b1;
         expected_views.delete();
         mismatches   = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == mds_pkg::CSR_PERIOD)
               period_ticks = csr_write_data[mds_pkg::PERIOD_W-1:0];
            else if (csr_index == mds_pkg::CSR_BRIGHT)
               brightness = csr_write_data[mds_pkg::BRIGHT_W-1:0];
         end
         if (req_valid && !req_stall) begin
            scan_item(req_op, req_write_digit, req_write_pattern);
            want.sink   = sink_now;
            want.source = source_now;
            want.blank  = blank_now;
            want.digit  = digit_now;
            expected_views.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_views.size() == 0) begin
               note_mismatch("unexpected transaction", '0, rsp_sink_pattern);
            end else begin
               want = expected_views.pop_front();
               if (rsp_sink_pattern !== want.sink)
                  note_mismatch("sink_pattern", want.sink, rsp_sink_pattern);
               if (rsp_source_lines !== want.source)
                  note_mismatch("source_lines", want.source, rsp_source_lines);
               if (rsp_blank !== want.blank)
                  note_mismatch("blank", want.blank, rsp_blank);
               if (rsp_active_digit !== want.digit)
                  note_mismatch("active_digit", want.digit, rsp_active_digit);
            end
         end
      end
      pending = expected_views.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display scanner testbench
// Drives pattern writes and timer ticks into the scanner under a range of
// period and brightness settings, with random gaps on the request side and
// random stalls on the result side. The checker predicts every result and
// reports the mismatch count used for the verdict.
// ----------------------------------------------------------------------------
module testbench;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_op;
   logic [mds_pkg::DIGIT_W-1:0]    req_write_digit;
   logic [mds_pkg::PATTERN_W-1:0]  req_write_pattern;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [mds_pkg::PATTERN_W-1:0]  rsp_sink_pattern;
   logic [mds_pkg::SOURCE_W-1:0]   rsp_source_lines;
   logic                           rsp_blank;
   logic [mds_pkg::DIGIT_W-1:0]    rsp_active_digit;
   logic                           csr_write_enable;
   logic [mds_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mds_pkg::CSR_DATA_W-1:0] csr_write_data;
   int                             mismatches;
   int                             pending;
   bit                             quiet_phase = 1'b0;
   int unsigned                    stall_left = 0;

   multiplexed_display_scanner u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_write_digit   (req_write_digit),
      .req_write_pattern (req_write_pattern),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sink_pattern  (rsp_sink_pattern),
      .rsp_source_lines  (rsp_source_lines),
      .rsp_blank         (rsp_blank),
      .rsp_active_digit  (rsp_active_digit),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   scan_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_write_digit   (req_write_digit),
      .req_write_pattern (req_write_pattern),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sink_pattern  (rsp_sink_pattern),
      .rsp_source_lines  (rsp_source_lines),
      .rsp_blank         (rsp_blank),
      .rsp_active_digit  (rsp_active_digit),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatches        (mismatches),
      .pending           (pending)
   );

   always #1 clock = ~clock;

   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      else if (roll < 94)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= idle_length();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_item(input logic op, input logic [mds_pkg::DIGIT_W-1:0] dig,
                            input logic [mds_pkg::PATTERN_W-1:0] pat);
      int unsigned gap;
      gap = quiet_phase ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_write_digit   <= dig;
      req_write_pattern <= pat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic push_tick();
      push_item(mds_pkg::OP_TICK, mds_pkg::DIGIT_W'($urandom),
                mds_pkg::PATTERN_W'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input logic [mds_pkg::CSR_DATA_W-1:0] period_word,
                              input logic [mds_pkg::CSR_DATA_W-1:0] bright_word);
      csr_write_enable <= 1'b1;
      csr_index        <= mds_pkg::CSR_PERIOD;
      csr_write_data   <= period_word;
      @(posedge clock);
      csr_index        <= mds_pkg::CSR_BRIGHT;
      csr_write_data   <= bright_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_op            <= mds_pkg::OP_WRITE;
      req_write_digit   <= '0;
      req_write_pattern <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= mds_pkg::CSR_PERIOD;
      csr_write_data    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_item(mds_pkg::OP_WRITE, mds_pkg::DIGIT_W'(0), 16'hFFFF);
      push_item(mds_pkg::OP_WRITE, mds_pkg::DIGIT_W'(1), 16'h0000);
      push_item(mds_pkg::OP_WRITE, mds_pkg::DIGIT_W'(6), 16'hA5A5);
      push_item(mds_pkg::OP_WRITE, mds_pkg::DIGIT_W'(7), 16'h5A5A);
      push_tick();

      settle();
      load_config(16'd0, 16'd100);
      repeat (7) push_tick();

      settle();
      load_config(16'd3, 16'd0);
      repeat (4) push_tick();

      settle();
      load_config(16'd10, 16'd50);
      repeat (8) push_tick();

      settle();
      load_config(16'd2, 16'd100);
      repeat (2) push_tick();

      for (int phase = 0; phase < 10; phase++) begin
         logic [mds_pkg::PERIOD_W-1:0] period_pick;
         logic [mds_pkg::BRIGHT_W-1:0] bright_pick;
         settle();
         quiet_phase <= ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       bright_pick = mds_pkg::BRIGHT_W'(0);
            1:       bright_pick = mds_pkg::BRIGHT_W'(100);
            2:       bright_pick = mds_pkg::BRIGHT_W'(127);
            default: bright_pick = mds_pkg::BRIGHT_W'($urandom_range(0, 99));
         endcase
         if ($urandom_range(0, 3) == 0)
            period_pick = mds_pkg::PERIOD_W'($urandom_range(13, 60));
         else
            period_pick = mds_pkg::PERIOD_W'($urandom_range(1, 12));
         if (phase == 0) begin
            period_pick = 16'hFFFF;
            bright_pick = mds_pkg::BRIGHT_W'(99);
         end else if (phase == 1) begin
            period_pick = mds_pkg::PERIOD_W'(1);
            bright_pick = mds_pkg::BRIGHT_W'(0);
         end else if (phase == 2) begin
            period_pick = mds_pkg::PERIOD_W'(0);
            bright_pick = mds_pkg::BRIGHT_W'(127);
         end
         load_config(period_pick, {9'($urandom), bright_pick});
         repeat (40) begin
            if ($urandom_range(0, 9) < 7)
               push_tick();
            else
               push_item(mds_pkg::OP_WRITE, mds_pkg::DIGIT_W'($urandom_range(0, 7)),
                         mds_pkg::PATTERN_W'($urandom));
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### multiplexed_display_scanner.f
+incdir+rtl/core
rtl/core/mds_pkg.sv
rtl/core/mds_pattern_store.sv
rtl/core/multiplexed_display_scanner.sv
dv/scan_checker.sv
dv/testbench.sv
